/* hdl/rc5_pkg.sv */
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared widths, register indexes, reset values and frame field positions
// for the RC5 infrared edge decoder.
// ----------------------------------------------------------------------------
package rc5_pkg;

  // Timer and limit widths.
  localparam int TIME_W  = 16;
  localparam int HALF_W  = 8;
  localparam int BITC_W  = 4;
  localparam int WORD_W  = 16;

  // Frame length in bits.
  localparam int FRAME_BITS_DEF = 13;

  // Decoded field widths.
  localparam int CMD_W  = 6;
  localparam int ADDR_W = 5;

  // Field positions inside the shift word.
  localparam int CMD_LSB    = 0;
  localparam int ADDR_LSB   = 6;
  localparam int TOGGLE_POS = 11;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HALF_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HALF_BIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BIT      = 2'd2;

  // Limit values after reset, in timer ticks.
  localparam logic [TIME_W-1:0] MIN_HALF_BIT_RST = 16'd1000;
  localparam logic [TIME_W-1:0] MAX_HALF_BIT_RST = 16'd2600;
  localparam logic [TIME_W-1:0] MAX_BIT_RST      = 16'd4200;

  // Input operation codes.
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_ACK  = 1'b1;

endpackage

/* hdl/rc5_ir_edge_decoder.sv */
// ----------------------------------------------------------------------------
// rc5_ir_edge_decoder
// Decodes RC5 infrared frames from edge timestamps and holds the last frame
// until it is acknowledged.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one beat per edge or per
//   acknowledge: operation selects edge capture or acknowledge, timestamp is
//   the free-running timer value at the edge. Every input beat yields exactly
//   one result beat on the output channel (out_valid/out_stall) with the
//   frame_done strobe, the held command, address and toggle, and the pending
//   flag as it stands after that beat.
//   The beat sits in the input register, then the decode logic writes the
//   result register. One beat is taken every cycle while the receiver
//   does not stall; the rate is set by the single decode step that
//   updates the frame state between those two registers.
//   When the receiver stalls, the result register holds its beat, the input
//   register takes one more beat and then in_stall rises until the result
//   is taken.
//   The limit registers are written through cfg_valid/cfg_ready, which is
//   always ready; the user must write them while the block is idle, as the block does not enforce it.
//   Synchronous reset clears both registers' valid flags and the frame
//   state and loads the default limits.
// ----------------------------------------------------------------------------
module rc5_ir_edge_decoder #(
  parameter int FRAME_BITS = rc5_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             operation,
  input  logic [rc5_pkg::TIME_W-1:0]       timestamp,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_done,
  output logic [rc5_pkg::CMD_W-1:0]        command,
  output logic [rc5_pkg::ADDR_W-1:0]       address,
  output logic                             toggle,
  output logic                             data_pending,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rc5_pkg::TIME_W-1:0]       cfg_data
);

  localparam logic [rc5_pkg::BITC_W-1:0] LAST_BIT = rc5_pkg::BITC_W'(FRAME_BITS - 1);

  // Limit registers.
  logic [rc5_pkg::TIME_W-1:0] min_half_bit;
  logic [rc5_pkg::TIME_W-1:0] max_half_bit;
  logic [rc5_pkg::TIME_W-1:0] max_bit;

  // Input register.
  logic                       s1_valid;
  logic                       s1_op;
  logic [rc5_pkg::TIME_W-1:0] s1_ts;

  // Frame state.
  logic [rc5_pkg::TIME_W-1:0] last_time;
  logic                       edge_polarity;
  logic [rc5_pkg::HALF_W-1:0] half_count;
  logic [rc5_pkg::BITC_W-1:0] bit_count;
  logic [rc5_pkg::WORD_W-1:0] shift_word;
  logic [rc5_pkg::CMD_W-1:0]  held_command;
  logic [rc5_pkg::ADDR_W-1:0] held_address;
  logic                       held_toggle;
  logic                       pending;

  // Next values from the decode step.
  logic [rc5_pkg::TIME_W-1:0] last_time_next;
  logic                       edge_polarity_next;
  logic [rc5_pkg::HALF_W-1:0] half_count_next;
  logic [rc5_pkg::BITC_W-1:0] bit_count_next;
  logic [rc5_pkg::WORD_W-1:0] shift_word_next;
  logic [rc5_pkg::CMD_W-1:0]  held_command_next;
  logic [rc5_pkg::ADDR_W-1:0] held_address_next;
  logic                       held_toggle_next;
  logic                       pending_next;
  logic                       done_next;

  logic                       advance;

  // The result register is free when empty or being taken this cycle.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_half_bit <= rc5_pkg::MIN_HALF_BIT_RST;
      max_half_bit <= rc5_pkg::MAX_HALF_BIT_RST;
      max_bit      <= rc5_pkg::MAX_BIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rc5_pkg::REG_MIN_HALF_BIT: min_half_bit <= cfg_data;
        rc5_pkg::REG_MAX_HALF_BIT: max_half_bit <= cfg_data;
        rc5_pkg::REG_MAX_BIT:      max_bit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_op <= operation;
      s1_ts <= timestamp;
    end
  end

  // Decode step for the beat in the input register.
  always_comb begin
    logic [rc5_pkg::TIME_W-1:0] width;
    logic [rc5_pkg::HALF_W-1:0] hc0;
    logic [rc5_pkg::HALF_W-1:0] hc1;
    logic [rc5_pkg::BITC_W-1:0] bc1;
    logic [rc5_pkg::WORD_W-1:0] sw1;
    logic                       pol1;
    logic                       restart;

    last_time_next     = last_time;
    edge_polarity_next = edge_polarity;
    half_count_next    = half_count;
    bit_count_next     = bit_count;
    shift_word_next    = shift_word;
    held_command_next  = held_command;
    held_address_next  = held_address;
    held_toggle_next   = held_toggle;
    pending_next       = pending;
    done_next          = 1'b0;

    width   = s1_ts - last_time;
    pol1    = ~edge_polarity;
    hc0     = (width > max_bit) ? '0 : half_count;
    hc1     = (width > max_half_bit) ? hc0 + 1'b1 : hc0;
    bc1     = bit_count + 1'b1;
    sw1     = {shift_word[rc5_pkg::WORD_W-2:0], pol1};
    restart = 1'b0;

    if (s1_op == rc5_pkg::OP_ACK) begin
      pending_next = 1'b0;
    end else begin
      last_time_next     = s1_ts;
      edge_polarity_next = pol1;
      if (hc0 == '0) begin
        // First edge of a frame only starts reception.
        edge_polarity_next = 1'b1;
        bit_count_next     = '0;
        shift_word_next    = '0;
        half_count_next    = 8'd1;
      end else if (width < min_half_bit) begin
        restart = 1'b1;
      end else begin
        // Every second half bit completes a bit.
        if (hc1 > 8'd1 && !hc1[0]) begin
          shift_word_next = sw1;
          bit_count_next  = bc1;
          if (bc1 > LAST_BIT) begin
            if (!pending) begin
              held_command_next = sw1[rc5_pkg::CMD_LSB +: rc5_pkg::CMD_W];
              held_address_next = sw1[rc5_pkg::ADDR_LSB +: rc5_pkg::ADDR_W];
              held_toggle_next  = sw1[rc5_pkg::TOGGLE_POS];
            end
            pending_next = 1'b1;
            done_next    = 1'b1;
            restart      = 1'b1;
          end
        end
        half_count_next = hc1 + 1'b1;
      end
      if (restart) begin
        half_count_next    = '0;
        edge_polarity_next = 1'b0;
      end
    end
  end

  // Frame state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time     <= '0;
      edge_polarity <= 1'b0;
      half_count    <= '0;
      bit_count     <= '0;
      shift_word    <= '0;
      held_command  <= '0;
      held_address  <= '0;
      held_toggle   <= 1'b0;
      pending       <= 1'b0;
    end else if (advance) begin
      last_time     <= last_time_next;
      edge_polarity <= edge_polarity_next;
      half_count    <= half_count_next;
      bit_count     <= bit_count_next;
      shift_word    <= shift_word_next;
      held_command  <= held_command_next;
      held_address  <= held_address_next;
      held_toggle   <= held_toggle_next;
      pending       <= pending_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_done   <= done_next;
      command      <= held_command_next;
      address      <= held_address_next;
      toggle       <= held_toggle_next;
      data_pending <= pending_next;
    end
  end

`ifndef SYNTHESIS
  // A finished frame always leaves the pending flag set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_done || data_pending))
    else $error("frame_done without data_pending");

  // The input side stalls only behind a held result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held result");

  // An acknowledge clears the pending flag.
  assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == rc5_pkg::OP_ACK) |=> !pending)
    else $error("acknowledge left pending set");

  // A finished frame restarts reception.
  assert property (@(posedge clk) disable iff (rst)
    (advance && done_next) |=> (half_count == '0 && !edge_polarity))
    else $error("reception not restarted after a frame");
`endif

endmodule
